/* sv/cbdd_pkg.sv */
// Shared types and constants of the CPU bus decoder with sprite DMA.
`default_nettype none
package cbdd_pkg;

  // request kinds
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_RETURN = 2'd3
  } op_t;

  // decoded destinations
  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_RAM   = 3'd1,
    TGT_PPU   = 3'd2,
    TGT_CART  = 3'd3,
    TGT_APU   = 3'd4,
    TGT_PAD   = 3'd5,
    TGT_DMA   = 3'd6
  } target_t;

  // bus map
  localparam logic [15:0] ADDR_CART_BASE = 16'h8000;
  localparam logic [15:0] ADDR_RAM_LAST  = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_LAST  = 16'h3FFF;
  localparam logic [15:0] ADDR_DMA_START = 16'h4014;
  localparam logic [15:0] ADDR_APU_LAST  = 16'h4015;
  localparam logic [15:0] ADDR_PAD_FIRST = 16'h4016;
  localparam logic [15:0] ADDR_PAD_SECOND = 16'h4017;

  // span of the mirrored RAM window
  localparam int RAM_SPAN = 8192;

  // last sprite memory byte index
  localparam logic [7:0] OAM_LAST = 8'hFF;

  // tick phase counter (modulo six)
  localparam logic [2:0] PHASE_RESET = 3'd1;
  localparam logic [2:0] PHASE_LAST  = 3'd5;
  localparam logic [2:0] PHASE_SLOT_A = 3'd0;
  localparam logic [2:0] PHASE_SLOT_B = 3'd3;

  // work RAM strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

  // one result as held in the result register
  typedef struct packed {
    target_t     target;
    logic [15:0] local_addr;
    logic        is_write;
    logic [7:0]  write_data;
    logic [7:0]  rd_byte;
    logic        ram_sel;
    logic        ppu_step;
    logic        cpu_step;
    logic        dma_read_req;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_active;
  } res_t;

endpackage
`default_nettype wire

/* sv/console_cpu_bus_decoder_dma_core.sv */
// Top level: input register, decoder core, work RAM and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | request   | in_valid/in_stall  | op, addr, data, buttons
//   out     | result    | out_valid/out_stall| target, local_addr, is_write, write_data,
//           |           |                    | read_data, ppu_step, cpu_step, dma_read_req,
//           |           |                    | oam_write, oam_index, oam_data, dma_active
//
// One request per cycle while in_stall is low; each request is taken into the input register,
// then decoded into the result register alongside the RAM read.
// After reset the work RAM is swept to zero, with in_stall high.
// out_stall holds the result register and, through it, the input register; in_stall
// rises only during the RAM sweep or while the input register is full and cannot move on.
`default_nettype none
module console_cpu_bus_decoder_dma_core #(
  parameter int RAM_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  input  wire logic [7:0]  buttons,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       target,
  output logic [15:0]      local_addr,
  output logic             is_write,
  output logic [7:0]       write_data,
  output logic [7:0]       read_data,
  output logic             ppu_step,
  output logic             cpu_step,
  output logic             dma_read_req,
  output logic             oam_write,
  output logic [7:0]       oam_index,
  output logic [7:0]       oam_data,
  output logic             dma_active
);

  localparam int AW = $clog2(RAM_BYTES);

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data, s1_buttons;
  logic        advance, accept;
  logic        clr_busy;

  cbdd_pkg::res_t     res_next, res;
  cbdd_pkg::ram_ctl_t ram_ctl;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_wdata, ram_rdata;

  // handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr_busy || (s1_valid && !advance);
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= op;
      s1_addr    <= addr;
      s1_data    <= data;
      s1_buttons <= buttons;
    end
  end

  cbdd_core #(
    .RAM_BYTES (RAM_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .op        (s1_op),
    .addr      (s1_addr),
    .data      (s1_data),
    .buttons   (s1_buttons),
    .ram_rdata (ram_rdata),
    .res_next  (res_next),
    .ram_ctl   (ram_ctl),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  cbdd_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ram_ctl),
    .ram_addr (ram_addr),
    .wdata    (ram_wdata),
    .rdata    (ram_rdata),
    .clr_busy (clr_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // outputs; RAM bytes come straight from the RAM read register
  assign target       = res.target;
  assign local_addr   = res.local_addr;
  assign is_write     = res.is_write;
  assign write_data   = res.write_data;
  assign read_data    = res.ram_sel ? ram_rdata : res.rd_byte;
  assign ppu_step     = res.ppu_step;
  assign cpu_step     = res.cpu_step;
  assign dma_read_req = res.dma_read_req;
  assign oam_write    = res.oam_write;
  assign oam_index    = res.oam_index;
  assign oam_data     = res.oam_data;
  assign dma_active   = res.dma_active;

endmodule
`default_nettype wire

/* sv/cbdd_ram.sv */
// Work RAM with registered read and a clearing sweep after reset.
`default_nettype none
module cbdd_ram #(
  parameter int RAM_BYTES = 2048,
  localparam int AW = $clog2(RAM_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cbdd_pkg::ram_ctl_t ctl,
  input  wire logic [AW-1:0]     ram_addr,
  input  wire logic [7:0]        wdata,
  output logic [7:0]             rdata,
  output logic                   clr_busy
);

  logic [7:0]    mem [RAM_BYTES];
  logic [AW-1:0] clr_addr;

  // clearing sweep, one byte a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(RAM_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // single write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= 8'h00;
    end else if (ctl.wr_en) begin
      mem[ram_addr] <= wdata;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[ram_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/cbdd_core.sv */
// Address decode, controller ports, tick phase and sprite DMA sequencing.
`default_nettype none
module cbdd_core #(
  parameter int RAM_BYTES = 2048,
  localparam int AW = $clog2(RAM_BYTES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [1:0]         op,
  input  wire logic [15:0]        addr,
  input  wire logic [7:0]         data,
  input  wire logic [7:0]         buttons,
  input  wire logic [7:0]         ram_rdata,
  output cbdd_pkg::res_t          res_next,
  output cbdd_pkg::ram_ctl_t      ram_ctl,
  output logic [AW-1:0]           ram_addr,
  output logic [7:0]              ram_wdata
);

  // mirror folding steps: subtract RAM_BYTES << k for k = QBITS-1 .. 0
  localparam int QBITS = $clog2(cbdd_pkg::RAM_SPAN / RAM_BYTES + 1);

  // state
  logic [7:0] pad_first, pad_second;
  logic       strobe_last;
  logic [7:0] dma_page, dma_index;
  logic       dma_busy, dma_align;
  logic [7:0] dma_byte;
  logic       byte_from_ram;
  logic [2:0] tick_phase;

  logic [7:0] pad_first_next, pad_second_next;
  logic       strobe_last_next;
  logic [7:0] dma_page_next, dma_index_next;
  logic       dma_busy_next, dma_align_next;
  logic [7:0] dma_byte_next;
  logic       byte_from_ram_next;
  logic [2:0] tick_phase_next;

  // access request for the decoder
  logic        acc_en, acc_wr, dma_src;
  logic [15:0] acc_addr;
  logic [7:0]  acc_data;
  logic        slot;
  logic [7:0]  dma_byte_eff;
  logic        ram_rd, ram_wr;

  // fold a RAM window address onto the physical RAM
  function automatic logic [AW-1:0] ram_offset(input logic [12:0] a);
    logic [13:0] r;
    logic [13:0] step;
    r = {1'b0, a};
    for (int k = QBITS - 1; k >= 0; k--) begin
      step = 14'(RAM_BYTES) << k;
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[AW-1:0];
  endfunction

  // a RAM byte read by the DMA lands in the RAM output register
  assign dma_byte_eff = byte_from_ram ? ram_rdata : dma_byte;
  assign slot = (tick_phase == cbdd_pkg::PHASE_SLOT_A) ||
                (tick_phase == cbdd_pkg::PHASE_SLOT_B);

  // pick the access for this request
  always_comb begin
    acc_en   = 1'b0;
    acc_wr   = 1'b0;
    acc_addr = addr;
    acc_data = data;
    dma_src  = 1'b0;
    case (cbdd_pkg::op_t'(op))
      cbdd_pkg::OP_READ: begin
        acc_en = 1'b1;
      end
      cbdd_pkg::OP_WRITE: begin
        acc_en = 1'b1;
        acc_wr = 1'b1;
      end
      cbdd_pkg::OP_TICK: begin
        if (slot && dma_busy && !dma_align && tick_phase[0]) begin
          dma_src  = 1'b1;
          acc_en   = 1'b1;
          acc_addr = {dma_page, dma_index};
          acc_data = 8'h00;
        end
      end
      default: begin
        acc_en = 1'b0;
      end
    endcase
  end

  // decode, side effects and DMA sequencing
  always_comb begin
    res_next           = '0;
    pad_first_next     = pad_first;
    pad_second_next    = pad_second;
    strobe_last_next   = strobe_last;
    dma_page_next      = dma_page;
    dma_index_next     = dma_index;
    dma_busy_next      = dma_busy;
    dma_align_next     = dma_align;
    dma_byte_next      = dma_byte_eff;
    byte_from_ram_next = 1'b0;
    tick_phase_next    = tick_phase;
    ram_rd             = 1'b0;
    ram_wr             = 1'b0;
    ram_addr           = ram_offset(acc_addr[12:0]);
    ram_wdata          = acc_data;

    if (acc_en) begin
      res_next.local_addr = acc_addr;
      res_next.is_write   = acc_wr;
      res_next.write_data = acc_wr ? acc_data : 8'h00;
      if (acc_addr >= cbdd_pkg::ADDR_CART_BASE) begin
        res_next.target = cbdd_pkg::TGT_CART;
      end else if (acc_addr <= cbdd_pkg::ADDR_RAM_LAST) begin
        res_next.target     = cbdd_pkg::TGT_RAM;
        res_next.local_addr = 16'(ram_addr);
        res_next.ram_sel    = !acc_wr;
        ram_rd              = !acc_wr;
        ram_wr              = acc_wr;
      end else if (acc_addr <= cbdd_pkg::ADDR_PPU_LAST) begin
        res_next.target     = cbdd_pkg::TGT_PPU;
        res_next.local_addr = {13'd0, acc_addr[2:0]};
      end else if (acc_wr && acc_addr == cbdd_pkg::ADDR_DMA_START) begin
        res_next.target = cbdd_pkg::TGT_DMA;
        dma_page_next   = acc_data;
        dma_index_next  = 8'h00;
        dma_busy_next   = 1'b1;
      end else if (acc_addr == cbdd_pkg::ADDR_PAD_FIRST ||
                   acc_addr == cbdd_pkg::ADDR_PAD_SECOND) begin
        res_next.target = cbdd_pkg::TGT_PAD;
        if (acc_wr) begin
          // strobe falling edge latches the buttons
          if (strobe_last && !acc_data[0]) begin
            pad_first_next  = buttons;
            pad_second_next = 8'h00;
          end
          strobe_last_next = acc_data[0];
        end else if (acc_addr == cbdd_pkg::ADDR_PAD_FIRST) begin
          res_next.rd_byte = {7'd0, pad_first[7]};
          pad_first_next   = {pad_first[6:0], 1'b0};
        end else begin
          res_next.rd_byte = {7'd0, pad_second[7]};
          pad_second_next  = {pad_second[6:0], 1'b0};
        end
      end else if (acc_addr <= cbdd_pkg::ADDR_APU_LAST) begin
        res_next.target = cbdd_pkg::TGT_APU;
      end else begin
        res_next.target = cbdd_pkg::TGT_NONE;
      end
    end

    // DMA source byte: internal registers latch at once, a RAM byte comes via the RAM read register
    if (dma_src) begin
      res_next.dma_read_req = 1'b1;
      if (res_next.target == cbdd_pkg::TGT_RAM) begin
        byte_from_ram_next = 1'b1;
      end else if (res_next.target != cbdd_pkg::TGT_PPU &&
                   res_next.target != cbdd_pkg::TGT_CART) begin
        dma_byte_next = res_next.rd_byte;
      end
    end

    case (cbdd_pkg::op_t'(op))
      cbdd_pkg::OP_RETURN: begin
        dma_byte_next = data;
      end
      cbdd_pkg::OP_TICK: begin
        res_next.ppu_step = 1'b1;
        if (slot) begin
          if (!dma_busy) begin
            res_next.cpu_step = 1'b1;
          end else if (dma_align) begin
            if (!tick_phase[0]) begin
              dma_align_next = 1'b0;
            end
          end else if (!tick_phase[0]) begin
            // sprite memory write
            res_next.oam_write = 1'b1;
            res_next.oam_index = dma_index;
            res_next.oam_data  = dma_byte_eff;
            if (dma_index == cbdd_pkg::OAM_LAST) begin
              dma_index_next = 8'h00;
              dma_busy_next  = 1'b0;
              dma_align_next = 1'b1;
            end else begin
              dma_index_next = dma_index + 8'd1;
            end
          end
        end
        tick_phase_next = (tick_phase == cbdd_pkg::PHASE_LAST) ? 3'd0 : tick_phase + 3'd1;
      end
      default: begin
        tick_phase_next = tick_phase;
      end
    endcase

    res_next.dma_active = dma_busy_next;
  end

  assign ram_ctl.rd_en = advance && ram_rd;
  assign ram_ctl.wr_en = advance && ram_wr;

  // state update on every processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_first     <= 8'h00;
      pad_second    <= 8'h00;
      strobe_last   <= 1'b0;
      dma_page      <= 8'h00;
      dma_index     <= 8'h00;
      dma_busy      <= 1'b0;
      dma_align     <= 1'b1;
      dma_byte      <= 8'h00;
      byte_from_ram <= 1'b0;
      tick_phase    <= cbdd_pkg::PHASE_RESET;
    end else if (advance) begin
      pad_first     <= pad_first_next;
      pad_second    <= pad_second_next;
      strobe_last   <= strobe_last_next;
      dma_page      <= dma_page_next;
      dma_index     <= dma_index_next;
      dma_busy      <= dma_busy_next;
      dma_align     <= dma_align_next;
      dma_byte      <= dma_byte_next;
      byte_from_ram <= byte_from_ram_next;
      tick_phase    <= tick_phase_next;
    end
  end

endmodule
`default_nettype wire

/* sim/console_cpu_bus_decoder_dma_core_test.sv */
// Self-checking testbench of the CPU bus decoder with sprite DMA.
`default_nettype none
module console_cpu_bus_decoder_dma_core_test;

  localparam int RAM_BYTES = 2048;
  localparam int PLAN_LEN = 26;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int CYCLE_LIMIT = 400000;

  // one result as the decoder reports it
  typedef struct packed {
    cbdd_pkg::target_t target;
    logic [15:0] local_addr;
    logic        is_write;
    logic [7:0]  write_data;
    logic [7:0]  read_data;
    logic        ppu_step;
    logic        cpu_step;
    logic        dma_read_req;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_active;
  } bus_result_t;

  // directed request, with the decode typed in where it is obvious
  typedef struct {
    cbdd_pkg::op_t     op;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic [7:0]        buttons;
    bit                typed;
    cbdd_pkg::target_t target;
    logic [15:0]       local_addr;
    logic [7:0]        read_data;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  cbdd_pkg::op_t op = cbdd_pkg::OP_READ;
  logic [15:0]   addr = 16'h0000;
  logic [7:0]    data = 8'h00;
  logic [7:0]    buttons = 8'h00;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [2:0]    target;
  logic [15:0]   local_addr;
  logic          is_write;
  logic [7:0]    write_data;
  logic [7:0]    read_data;
  logic          ppu_step;
  logic          cpu_step;
  logic          dma_read_req;
  logic          oam_write;
  logic [7:0]    oam_index;
  logic [7:0]    oam_data;
  logic          dma_active;

  console_cpu_bus_decoder_dma_core #(.RAM_BYTES(RAM_BYTES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .addr(addr), .data(data), .buttons(buttons),
    .out_valid(out_valid), .out_stall(out_stall),
    .target(target), .local_addr(local_addr), .is_write(is_write),
    .write_data(write_data), .read_data(read_data), .ppu_step(ppu_step),
    .cpu_step(cpu_step), .dma_read_req(dma_read_req), .oam_write(oam_write),
    .oam_index(oam_index), .oam_data(oam_data), .dma_active(dma_active)
  );

  always #5 clk = ~clk;

  // shadow state of the bus
  logic [7:0] ram_img [0:RAM_BYTES-1];
  logic [7:0] pad_first, pad_second;
  logic       strobe_q;
  logic [7:0] dma_page_q, dma_idx_q, dma_byte_q;
  logic       dma_busy_q, dma_wait_q;
  logic [2:0] phase_q;

  bus_result_t due_results [$];
  plan_row_t   plan [0:PLAN_LEN-1];
  int fails = 0, sent = 0, checked = 0, sprite_copies = 0, oam_writes = 0, cycles = 0;
  bit tx_idle = 1'b1, rx_idle = 1'b1, took = 1'b0, hold = 1'b0;
  int stall_left = 0, hold_cycles = 0;

  // decode one access and apply its side effects; 1 if the byte comes from inside
  function automatic bit decode_access(input logic [15:0] a, input bit wr,
                                       input logic [7:0] d, input logic [7:0] btn,
                                       inout bus_result_t r);
    logic [7:0] rd;
    bit internal;
    int unsigned off;
    rd = 8'h00;
    internal = 1'b1;
    r.local_addr = a;
    r.is_write = wr;
    r.write_data = wr ? d : 8'h00;
    if (a >= cbdd_pkg::ADDR_CART_BASE) begin
      r.target = cbdd_pkg::TGT_CART;
      internal = 1'b0;
    end else if (a <= cbdd_pkg::ADDR_RAM_LAST) begin
      off = a % RAM_BYTES;
      r.target = cbdd_pkg::TGT_RAM;
      r.local_addr = off[15:0];
      if (wr) ram_img[off] = d;
      else rd = ram_img[off];
    end else if (a <= cbdd_pkg::ADDR_PPU_LAST) begin
      r.target = cbdd_pkg::TGT_PPU;
      r.local_addr = {13'd0, a[2:0]};
      internal = 1'b0;
    end else if (wr && a == cbdd_pkg::ADDR_DMA_START) begin
      // start, or restart mid-transfer; the alignment wait is kept
      r.target = cbdd_pkg::TGT_DMA;
      dma_page_q = d;
      dma_idx_q = 8'h00;
      dma_busy_q = 1'b1;
    end else if (a == cbdd_pkg::ADDR_PAD_FIRST || a == cbdd_pkg::ADDR_PAD_SECOND) begin
      r.target = cbdd_pkg::TGT_PAD;
      if (wr) begin
        if (strobe_q && !d[0]) begin
          pad_first = btn;
          pad_second = 8'h00;
        end
        strobe_q = d[0];
      end else if (a == cbdd_pkg::ADDR_PAD_FIRST) begin
        rd = {7'd0, pad_first[7]};
        pad_first = pad_first << 1;
      end else begin
        rd = {7'd0, pad_second[7]};
        pad_second = pad_second << 1;
      end
    end else if (a <= cbdd_pkg::ADDR_APU_LAST) begin
      r.target = cbdd_pkg::TGT_APU;
    end else begin
      r.target = cbdd_pkg::TGT_NONE;
    end
    r.read_data = rd;
    return internal;
  endfunction

  // expected result of one request, advancing the shadow state
  function automatic bus_result_t bus_outcome(input cbdd_pkg::op_t o, input logic [15:0] a,
                                              input logic [7:0] d, input logic [7:0] btn);
    bus_result_t r;
    r = '0;
    case (o)
      cbdd_pkg::OP_READ, cbdd_pkg::OP_WRITE:
        void'(decode_access(a, o == cbdd_pkg::OP_WRITE, d, btn, r));
      cbdd_pkg::OP_RETURN: dma_byte_q = d;
      default: begin
        r.ppu_step = 1'b1;
        if (phase_q == cbdd_pkg::PHASE_SLOT_A || phase_q == cbdd_pkg::PHASE_SLOT_B) begin
          if (!dma_busy_q) begin
            r.cpu_step = 1'b1;
          end else if (dma_wait_q) begin
            // wait for an even slot before the first read
            if (!phase_q[0]) dma_wait_q = 1'b0;
          end else if (phase_q[0]) begin
            r.dma_read_req = 1'b1;
            if (decode_access({dma_page_q, dma_idx_q}, 1'b0, 8'h00, btn, r))
              dma_byte_q = r.read_data;
          end else begin
            r.oam_write = 1'b1;
            r.oam_index = dma_idx_q;
            r.oam_data = dma_byte_q;
            oam_writes++;
            if (dma_idx_q >= cbdd_pkg::OAM_LAST) begin
              dma_idx_q = 8'h00;
              dma_busy_q = 1'b0;
              dma_wait_q = 1'b1;
              sprite_copies++;
            end else begin
              dma_idx_q = dma_idx_q + 8'd1;
            end
          end
        end
        phase_q = (phase_q == cbdd_pkg::PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
      end
    endcase
    r.dma_active = dma_busy_q;
    return r;
  endfunction

  // offer one request, wait for it to be taken, return its expected result
  task automatic push_request(input cbdd_pkg::op_t o, input logic [15:0] a,
                              input logic [7:0] d, input logic [7:0] b,
                              output bus_result_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    addr <= a;
    data <= d;
    buttons <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = bus_outcome(o, a, d, b);
    sent++;
  endtask

  // address biased towards the interesting corners of the map
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    case ($urandom_range(0, 7))
      0, 1: a = 16'(($urandom_range(0, 3) * RAM_BYTES) +
                    ($urandom_range(0, 1) ? $urandom_range(0, 15)
                                          : $urandom_range(RAM_BYTES - 16, RAM_BYTES - 1)));
      2: a = 16'($urandom_range(16'h2000, 16'h3FFF));
      3: a = 16'(16'h4000 + $urandom_range(0, 23));
      4: a = $urandom_range(0, 1) ? cbdd_pkg::ADDR_PAD_FIRST : cbdd_pkg::ADDR_PAD_SECOND;
      5: a = 16'($urandom_range(16'h4018, 16'h7FFF));
      6: a = 16'($urandom_range(16'h8000, 16'hFFFF));
      default: a = 16'($urandom_range(0, 65535));
    endcase
    return a;
  endfunction

  // mostly ticks while a transfer runs so that transfers finish; no restarts then
  task automatic pick_request(output cbdd_pkg::op_t o, output logic [15:0] a,
                              output logic [7:0] d);
    int roll;
    roll = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    a = pick_addr();
    if (!dma_busy_q && roll < 3) begin
      o = cbdd_pkg::OP_WRITE;
      a = cbdd_pkg::ADDR_DMA_START;
    end else if (roll < (dma_busy_q ? 90 : 50)) begin
      o = cbdd_pkg::OP_TICK;
    end else if (roll < (dma_busy_q ? 94 : 70)) begin
      o = cbdd_pkg::OP_READ;
    end else if (roll < (dma_busy_q ? 98 : 90)) begin
      o = cbdd_pkg::OP_WRITE;
      if (dma_busy_q && a == cbdd_pkg::ADDR_DMA_START) a = cbdd_pkg::ADDR_PAD_FIRST;
    end else begin
      o = cbdd_pkg::OP_RETURN;
    end
  endtask

  // compare one field
  task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= 10)
        $display("mismatch on %s at result %0d: expected %h, got %h", name, checked, want, got);
    end
  endtask

  // result side: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      bus_result_t want;
      took = 1'b1;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("result with no request outstanding, target %0d", target);
      end else begin
        want = due_results.pop_front();
        note_field("target", {13'd0, want.target}, {13'd0, target});
        note_field("local_addr", want.local_addr, local_addr);
        note_field("is_write", {15'd0, want.is_write}, {15'd0, is_write});
        note_field("write_data", {8'd0, want.write_data}, {8'd0, write_data});
        note_field("read_data", {8'd0, want.read_data}, {8'd0, read_data});
        note_field("ppu_step", {15'd0, want.ppu_step}, {15'd0, ppu_step});
        note_field("cpu_step", {15'd0, want.cpu_step}, {15'd0, cpu_step});
        note_field("dma_read_req", {15'd0, want.dma_read_req}, {15'd0, dma_read_req});
        note_field("oam_write", {15'd0, want.oam_write}, {15'd0, oam_write});
        note_field("oam_index", {8'd0, want.oam_index}, {8'd0, oam_index});
        note_field("oam_data", {8'd0, want.oam_data}, {8'd0, oam_data});
        note_field("dma_active", {15'd0, want.dma_active}, {15'd0, dma_active});
        checked++;
      end
    end
  end

  // result side stall, redrawn after each taken result
  always @(negedge clk) begin
    if (took) begin
      took = 1'b0;
      stall_left = rx_idle ? $urandom_range(0, 7) : 0;
    end
    out_stall <= hold || (stall_left != 0);
    if (!hold && stall_left != 0) stall_left--;
  end

  // long hold-off of the result side, counted here
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    bus_result_t   r;
    cbdd_pkg::op_t o;
    logic [15:0]   a;
    logic [7:0]    d;
    for (int i = 0; i < RAM_BYTES; i++) ram_img[i] = 8'h00;
    pad_first = 8'h00;
    pad_second = 8'h00;
    strobe_q = 1'b0;
    dma_page_q = 8'h00;
    dma_idx_q = 8'h00;
    dma_byte_q = 8'h00;
    dma_busy_q = 1'b0;
    dma_wait_q = 1'b1;
    phase_q = cbdd_pkg::PHASE_RESET;

    // directed part: map corners, mirrors, controller strobe and reads, ticks, DMA start, DMA byte return
    plan[0]  = '{cbdd_pkg::OP_READ,   16'h0000, 8'h00, 8'h00, 1, cbdd_pkg::TGT_RAM,
                 16'h0000, 8'h00};
    plan[1]  = '{cbdd_pkg::OP_WRITE,  16'h07FF, 8'hFF, 8'h00, 1, cbdd_pkg::TGT_RAM,
                 16'h07FF, 8'h00};
    plan[2]  = '{cbdd_pkg::OP_READ,   16'h1FFF, 8'h00, 8'h00, 1, cbdd_pkg::TGT_RAM,
                 16'h07FF, 8'hFF};
    plan[3]  = '{cbdd_pkg::OP_WRITE,  16'h0800, 8'h3C, 8'h00, 1, cbdd_pkg::TGT_RAM,
                 16'h0000, 8'h00};
    plan[4]  = '{cbdd_pkg::OP_READ,   16'h0000, 8'h00, 8'h00, 1, cbdd_pkg::TGT_RAM,
                 16'h0000, 8'h3C};
    plan[5]  = '{cbdd_pkg::OP_WRITE,  16'h2000, 8'hA5, 8'h00, 1, cbdd_pkg::TGT_PPU,
                 16'h0000, 8'h00};
    plan[6]  = '{cbdd_pkg::OP_READ,   16'h3FFF, 8'h00, 8'h00, 1, cbdd_pkg::TGT_PPU,
                 16'h0007, 8'h00};
    plan[7]  = '{cbdd_pkg::OP_READ,   16'h8000, 8'h00, 8'h00, 1, cbdd_pkg::TGT_CART,
                 16'h8000, 8'h00};
    plan[8]  = '{cbdd_pkg::OP_WRITE,  16'hFFFF, 8'h00, 8'h00, 1, cbdd_pkg::TGT_CART,
                 16'hFFFF, 8'h00};
    plan[9]  = '{cbdd_pkg::OP_READ,   16'h4000, 8'h00, 8'h00, 1, cbdd_pkg::TGT_APU,
                 16'h4000, 8'h00};
    plan[10] = '{cbdd_pkg::OP_READ,   16'h4014, 8'h00, 8'h00, 1, cbdd_pkg::TGT_APU,
                 16'h4014, 8'h00};
    plan[11] = '{cbdd_pkg::OP_WRITE,  16'h4015, 8'h5A, 8'h00, 1, cbdd_pkg::TGT_APU,
                 16'h4015, 8'h00};
    plan[12] = '{cbdd_pkg::OP_READ,   16'h4018, 8'h00, 8'h00, 1, cbdd_pkg::TGT_NONE,
                 16'h4018, 8'h00};
    plan[13] = '{cbdd_pkg::OP_WRITE,  16'h4016, 8'h01, 8'h00, 1, cbdd_pkg::TGT_PAD,
                 16'h4016, 8'h00};
    plan[14] = '{cbdd_pkg::OP_WRITE,  16'h4016, 8'h00, 8'h80, 1, cbdd_pkg::TGT_PAD,
                 16'h4016, 8'h00};
    plan[15] = '{cbdd_pkg::OP_READ,   16'h4016, 8'h00, 8'h00, 1, cbdd_pkg::TGT_PAD,
                 16'h4016, 8'h01};
    plan[16] = '{cbdd_pkg::OP_READ,   16'h4016, 8'h00, 8'h00, 1, cbdd_pkg::TGT_PAD,
                 16'h4016, 8'h00};
    plan[17] = '{cbdd_pkg::OP_WRITE,  16'h4017, 8'hFF, 8'h00, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};
    plan[18] = '{cbdd_pkg::OP_WRITE,  16'h4017, 8'hFE, 8'hC3, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};
    plan[19] = '{cbdd_pkg::OP_READ,   16'h4016, 8'h00, 8'h00, 1, cbdd_pkg::TGT_PAD,
                 16'h4016, 8'h01};
    plan[20] = '{cbdd_pkg::OP_TICK,   16'h0000, 8'h00, 8'hFF, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};
    plan[21] = '{cbdd_pkg::OP_TICK,   16'hFFFF, 8'hFF, 8'h00, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};
    plan[22] = '{cbdd_pkg::OP_WRITE,  16'h4014, 8'h00, 8'h00, 1, cbdd_pkg::TGT_DMA,
                 16'h4014, 8'h00};
    plan[23] = '{cbdd_pkg::OP_WRITE,  16'h4014, 8'h80, 8'h00, 1, cbdd_pkg::TGT_DMA,
                 16'h4014, 8'h00};
    plan[24] = '{cbdd_pkg::OP_RETURN, 16'h1234, 8'h5A, 8'h00, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};
    plan[25] = '{cbdd_pkg::OP_READ,   16'h4017, 8'h00, 8'h00, 0, cbdd_pkg::TGT_NONE,
                 16'h0000, 8'h00};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      push_request(plan[i].op, plan[i].addr, plan[i].data, plan[i].buttons, r);
      if (plan[i].typed) begin
        r.target = plan[i].target;
        r.local_addr = plan[i].local_addr;
        r.read_data = plan[i].read_data;
      end
      due_results.push_back(r);
    end

    // random part, in segments with and without idling
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      // sender pauses until everything is back
      if (n == 1000) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end
      // receiver holds off long enough for the pipeline to back up
      if (n == 300) hold_cycles <= 300;
      pick_request(o, a, d);
      push_request(o, a, d, 8'($urandom_range(0, 255)), r);
      due_results.push_back(r);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests and checked %0d results over %0d cycles.", sent, checked, cycles);
    $display("Sprite transfers completed: %0d, sprite memory writes: %0d.",
             sprite_copies, oam_writes);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches in total", fails);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
sv/cbdd_pkg.sv
sv/cbdd_ram.sv
sv/cbdd_core.sv
sv/console_cpu_bus_decoder_dma_core.sv
sim/console_cpu_bus_decoder_dma_core_test.sv
